FILE: rtl/core/ostt_pkg.sv
`default_nettype none

package ostt_pkg;

  // fixed field widths of the stream items
  localparam int unsigned TimeoutW = 32;
  localparam int unsigned TagW     = 32;
  localparam int unsigned SlotInW  = 4;
  localparam int unsigned SlotOutW = 4;

  // defaults for the top level parameters
  localparam int unsigned DefNumSlots = 16;
  localparam int unsigned DefTickBits = 32;

  // request operation carried in tuser
  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_TICK   = 2'd2
  } mode_e;

  // result kind carried in tuser
  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_REJECT   = 2'd1,
    STAT_EXPIRED  = 2'd2,
    STAT_NO_FIRE  = 2'd3
  } status_e;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // resolve the request against the table, load the result
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/ostt_ctrl.sv
`default_nettype none

module ostt_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  output logic              m_axis_tvalid_o,
  input  wire               m_axis_tready_i,
  output ostt_pkg::cmd_t    cmd_o
);

  ostt_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             go;

  // result register is free or being drained this cycle
  assign go = !out_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ostt_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ostt_pkg::ST_EXEC;
      end
      ostt_pkg::ST_EXEC: begin
        if (go) state_d = ostt_pkg::ST_IDLE;
      end
      default: state_d = ostt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    case (state_q)
      ostt_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load      = s_axis_tvalid_i;
      end
      ostt_pkg::ST_EXEC: begin
        cmd_o.exec = go;
      end
      default: cmd_o = '0;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  assign m_axis_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ostt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ostt_dp.sv
`default_nettype none

module ostt_dp #(
  parameter int unsigned NUM_SLOTS = ostt_pkg::DefNumSlots,
  parameter int unsigned TICK_BITS = ostt_pkg::DefTickBits
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  ostt_pkg::cmd_t                cmd_i,
  input  wire [1:0]                     mode_i,
  input  wire [ostt_pkg::TimeoutW-1:0]  timeout_i,
  input  wire [ostt_pkg::TagW-1:0]      tag_i,
  input  wire [ostt_pkg::SlotInW-1:0]   slot_i,
  output logic [1:0]                    status_o,
  output logic [ostt_pkg::SlotOutW-1:0] slot_index_o,
  output logic [ostt_pkg::TagW-1:0]     fired_tag_o
);

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned SumW  = TICK_BITS + ostt_pkg::TimeoutW;

  // captured request
  ostt_pkg::mode_e              mode_q;
  logic [ostt_pkg::TimeoutW-1:0] timeout_q;
  logic [ostt_pkg::TagW-1:0]     tag_q;
  logic [ostt_pkg::SlotInW-1:0]  slot_q;

  // timer table
  logic [TICK_BITS-1:0]      tick_q;
  logic [NUM_SLOTS-1:0]      active_q, active_d;
  logic [TICK_BITS-1:0]      deadline_q [NUM_SLOTS];
  logic [ostt_pkg::TagW-1:0] stag_q     [NUM_SLOTS];

  // result register
  ostt_pkg::status_e          status_q, status_d;
  logic [SlotW-1:0]           idx_q, idx_d;
  logic [ostt_pkg::TagW-1:0]  ftag_q, ftag_d;

  logic             free_any, hit_any, del_ok, create_ok, wr_en;
  logic [SlotW-1:0] free_idx, hit_idx, del_idx;
  logic [SumW-1:0]  sum;

  // request capture, tick advances as the tick request is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= ostt_pkg::mode_e'(mode_i);
      timeout_q <= timeout_i;
      tag_q     <= tag_i;
      slot_q    <= slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (cmd_i.load && (mode_i == ostt_pkg::MODE_TICK)) begin
      tick_q <= tick_q + TICK_BITS'(1);
    end
  end

  // lowest free slot and lowest expired slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    hit_any  = 1'b0;
    hit_idx  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotW'(i);
      end
      if (active_q[i] && (tick_q >= deadline_q[i])) begin
        hit_any = 1'b1;
        hit_idx = SlotW'(i);
      end
    end
  end

  // deadline wraps to the tick width
  assign sum = {{TICK_BITS{1'b0}}, timeout_q} + {{ostt_pkg::TimeoutW{1'b0}}, tick_q};

  assign del_idx   = SlotW'(slot_q);
  assign del_ok    = (32'(slot_q) < NUM_SLOTS);
  assign create_ok = (tag_q != '0) && (timeout_q != '0) && free_any;

  // resolve the request
  always_comb begin
    active_d = active_q;
    status_d = ostt_pkg::STAT_DONE;
    idx_d    = '0;
    ftag_d   = '0;
    wr_en    = 1'b0;
    case (mode_q)
      ostt_pkg::MODE_CREATE: begin
        if (create_ok) begin
          active_d[free_idx] = 1'b1;
          idx_d              = free_idx;
          wr_en              = 1'b1;
        end else begin
          status_d = ostt_pkg::STAT_REJECT;
        end
      end
      ostt_pkg::MODE_DELETE: begin
        if (del_ok) active_d[del_idx] = 1'b0;
      end
      ostt_pkg::MODE_TICK: begin
        if (hit_any) begin
          active_d[hit_idx] = 1'b0;
          status_d          = ostt_pkg::STAT_EXPIRED;
          idx_d             = hit_idx;
          ftag_d            = stag_q[hit_idx];
        end else begin
          status_d = ostt_pkg::STAT_NO_FIRE;
        end
      end
      default: status_d = ostt_pkg::STAT_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.exec) begin
      active_q <= active_d;
    end
  end

  // slot payload, written on a successful create
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      deadline_q[free_idx] <= sum[TICK_BITS-1:0];
      stag_q[free_idx]     <= tag_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      idx_q    <= idx_d;
      ftag_q   <= ftag_d;
    end
  end

  assign status_o     = status_q;
  assign slot_index_o = ostt_pkg::SlotOutW'(idx_q);
  assign fired_tag_o  = ftag_q;

endmodule

`default_nettype wire

FILE: rtl/core/one_shot_timer_table.sv
`default_nettype none

// One-shot timer table. Each request on the input stream is a create, a
// delete or a tick (tuser); every request gives exactly one result on the
// output stream. A create takes the lowest free slot and arms it with the
// current tick plus the timeout; a tick advances the wrapping tick counter
// and fires the lowest armed slot whose deadline has been reached, at most
// one per tick. A request is first captured and then resolved against the
// whole table in a single parallel compare with a priority pick. The
// resolve step waits while an earlier result sits untaken in the output
// register; a new request is accepted while a result waits. All slots are
// free after reset, with no clearing pass.
module one_shot_timer_table #(
  parameter int unsigned NUM_SLOTS = ostt_pkg::DefNumSlots,
  parameter int unsigned TICK_BITS = ostt_pkg::DefTickBits
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [71:0] s_axis_tdata_i,   // timeout[31:0], tag[63:32], slot[67:64], zero pad
  input  wire  [1:0]  s_axis_tuser_i,   // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // slot_index[3:0], fired_tag[35:4], zero pad
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  ostt_pkg::cmd_t             cmd;
  logic [ostt_pkg::SlotOutW-1:0] slot_index;
  logic [ostt_pkg::TagW-1:0]     fired_tag;

  ostt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  ostt_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (s_axis_tuser_i),
    .timeout_i    (s_axis_tdata_i[31:0]),
    .tag_i        (s_axis_tdata_i[63:32]),
    .slot_i       (s_axis_tdata_i[67:64]),
    .status_o     (m_axis_tuser_o),
    .slot_index_o (slot_index),
    .fired_tag_o  (fired_tag)
  );

  // result packing
  assign m_axis_tdata_o = {4'b0, fired_tag, slot_index};

endmodule

`default_nettype wire

FILE: rtl/core/ostt_chk.sv
`default_nettype none

module ostt_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_i,
  input wire        m_axis_tvalid_i,
  input wire        m_axis_tready_i,
  input wire [39:0] m_axis_tdata_i,   // slot_index[3:0], fired_tag[35:4], zero pad
  input wire [1:0]  m_axis_tuser_i    // status[1:0]
);

  // a waiting result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=> m_axis_tvalid_i)
    else $error("result dropped before it was taken");

  // one request in flight: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_i) |=> !s_axis_tready_i)
    else $error("request accepted while another is in flight");

  // with a free output register the result follows an accept via the capture and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_i && (!m_axis_tvalid_i || m_axis_tready_i))
      |=> ##1 m_axis_tvalid_i)
    else $error("result late with free output register");

  // only an expired timer reports a tag, and its tag is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |->
      ((m_axis_tuser_i == ostt_pkg::STAT_EXPIRED) == (m_axis_tdata_i[35:4] != 32'd0)))
    else $error("fired tag does not match status");

endmodule

bind one_shot_timer_table ostt_chk u_ostt_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
